>>> rtl/sab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types, codes and the sequencer state type for the suffix automaton.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int SymbolWidth = 5;
    localparam int IndexWidth  = 11;
    localparam int CountWidth  = 12;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]            operation;
        logic [SymbolWidth-1:0] symbol;
        logic [IndexWidth-1:0]  state_index;
    } sab_in_t;

    typedef struct packed {
        logic [CountWidth-1:0] state_count;
        logic [IndexWidth-1:0] new_state_link;
        logic                  cloned;
        logic [IndexWidth-1:0] read_target;
        logic                  full_res;
    } sab_out_t;

    typedef enum logic [4:0] {
        ST_INIT,        // clearing pass over transition store
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_AP_LEN,      // fetch len[last]
        ST_AP_LENW,
        ST_AP_ROWCLR,   // zero the new state's row
        ST_AP_T,        // walk 1: read trans[p][c]
        ST_AP_TW,
        ST_AP_TDEC,
        ST_AP_LINKW,
        ST_AP_QLEN,
        ST_AP_QLENW,
        ST_AP_PLENW,
        ST_AP_CPY_RD,   // copy row q -> clone
        ST_AP_CPY_WR,
        ST_AP_QLINKW,
        ST_AP_R,        // walk 2: redirect
        ST_AP_RW,
        ST_AP_RDEC,
        ST_AP_RLINKW,
        ST_AP_FIN,
        ST_RESP
    } sab_state_t;

endpackage

>>> rtl/sab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/suffix_automaton_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder_top
// Online suffix automaton builder with transition read and clear.
// ----------------------------------------------------------------------------
// One word at a time. After reset, and after every clear, a pass zeroes the
// transition store one entry per cycle and no word is taken meanwhile. A read
// passes through dispatch, issue, wait and response states. An append clears
// the new state's row and then walks the suffix links, checks len[q] against
// len[p] + 1 when the first walk finds an existing transition, and copies row
// q to a clone and runs the redirect walk when a clone is made; the single
// port of the transition RAM serialises these steps. The result register is
// freed as soon as the word is taken.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_top
    import sab_pkg::*;
#(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sab_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sab_out_t m_data
);

    localparam int MaxStates = 2 * MAX_LEN;
    localparam int SW        = $clog2(MaxStates);
    localparam int AW        = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TDepth    = MaxStates * ALPHABET;
    localparam int TW        = $clog2(TDepth);
    localparam int CW        = SW + 1;
    localparam int LW        = $clog2(MAX_LEN + 1);

    sab_state_t state_reg, state_next;

    logic [1:0]    op_reg;
    logic [SymbolWidth-1:0] sym_reg;
    logic [IndexWidth-1:0]  idx_reg;
    logic [SW-1:0] p_reg, q_reg, cur_reg, cl_reg, last_reg;
    logic [CW-1:0] used_reg;
    logic [LW-1:0] nsym_reg;
    logic [LW-1:0] plen_reg;
    logic [TW-1:0] sweep_reg;
    logic [AW-1:0] col_reg;
    logic [SW-1:0] cpy_reg;
    logic          found_reg;
    sab_out_t      res_reg;
    logic          mv_reg;

    // transition RAM
    logic          t_we;
    logic [TW-1:0] t_addr;
    logic [SW-1:0] t_wdata, t_rdata;
    // length RAM
    logic          l_we;
    logic [SW-1:0] l_addr;
    logic [LW-1:0] l_wdata, l_rdata;
    // link RAM
    logic          k_we;
    logic [SW-1:0] k_addr, k_wdata, k_rdata;

    sab_ram #(.Width(SW), .Depth(TDepth)) u_trans (
        .aclk(aclk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata));
    sab_ram #(.Width(LW), .Depth(MaxStates)) u_len (
        .aclk(aclk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
    sab_ram #(.Width(SW), .Depth(MaxStates)) u_link (
        .aclk(aclk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata));

    function automatic logic [TW-1:0] cell_addr(logic [SW-1:0] s, logic [AW-1:0] c);
        logic [TW:0] a;
        a = (TW+1)'(s) * (TW+1)'(ALPHABET) + (TW+1)'(c);
        return a[TW-1:0];
    endfunction

    logic [AW-1:0] csym;
    assign csym = AW'(sym_reg);
    logic sym_ok;
    assign sym_ok = ({27'd0, sym_reg} < 32'(ALPHABET));
    logic last_col;
    assign last_col = (32'(col_reg) == ALPHABET - 1);
    logic full_now;
    assign full_now = (32'(nsym_reg) >= MAX_LEN) || (32'(used_reg) + 2 > MaxStates);

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:      if (sweep_reg == TW'(TDepth - 1)) state_next = ST_IDLE;
            ST_IDLE:      if (s_valid && s_ready) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                case (op_reg)
                    OP_APPEND: state_next = (full_now || !sym_ok) ? ST_RESP : ST_AP_LEN;
                    OP_READ:   state_next = ST_RD_ISSUE;
                    OP_CLEAR:  state_next = ST_RESP;
                    default:   state_next = ST_RESP;
                endcase
            end
            ST_RD_ISSUE:  state_next = ST_RD_WAIT;
            ST_RD_WAIT:   state_next = ST_RESP;
            ST_AP_LEN:    state_next = ST_AP_LENW;
            ST_AP_LENW:   state_next = ST_AP_ROWCLR;
            ST_AP_ROWCLR: if (last_col) state_next = ST_AP_T;
            ST_AP_T:      state_next = ST_AP_TW;
            ST_AP_TW: begin
                if (t_rdata != '0) state_next = ST_AP_QLEN;
                else if (p_reg == '0) state_next = ST_AP_FIN;
                else state_next = ST_AP_TDEC;
            end
            ST_AP_TDEC:   state_next = ST_AP_LINKW;
            ST_AP_LINKW:  state_next = ST_AP_T;
            ST_AP_QLEN:   state_next = ST_AP_QLENW;
            ST_AP_QLENW:  state_next = ST_AP_PLENW;
            // plen_reg holds len[q], l_rdata holds len[p]
            ST_AP_PLENW:  state_next = (plen_reg == l_rdata + 1'b1) ? ST_AP_FIN
                                                                   : ST_AP_CPY_RD;
            ST_AP_CPY_RD: state_next = ST_AP_CPY_WR;
            ST_AP_CPY_WR: state_next = last_col ? ST_AP_QLINKW : ST_AP_CPY_RD;
            ST_AP_QLINKW: state_next = ST_AP_R;
            ST_AP_R:      state_next = ST_AP_RW;
            ST_AP_RW: begin
                if (t_rdata != q_reg || p_reg == '0) state_next = ST_AP_FIN;
                else state_next = ST_AP_RDEC;
            end
            ST_AP_RDEC:   state_next = ST_AP_RLINKW;
            ST_AP_RLINKW: state_next = ST_AP_R;
            ST_AP_FIN:    state_next = ST_RESP;
            ST_RESP:      state_next = (op_reg == OP_CLEAR) ? ST_INIT : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        t_we = 1'b0; t_addr = cell_addr(p_reg, csym); t_wdata = '0;
        l_we = 1'b0; l_addr = p_reg; l_wdata = '0;
        k_we = 1'b0; k_addr = p_reg; k_wdata = '0;
        case (state_reg)
            ST_INIT: begin
                t_we = 1'b1; t_addr = sweep_reg;
                l_we = 1'b1; l_addr = '0;
            end
            ST_RD_ISSUE: t_addr = cell_addr(SW'(idx_reg), csym);
            // p_reg holds the previous last state here
            ST_AP_LEN:   l_addr = p_reg;
            ST_AP_ROWCLR: begin
                t_we = 1'b1; t_addr = cell_addr(cur_reg, col_reg);
                if (col_reg == '0) begin
                    l_we = 1'b1; l_addr = cur_reg; l_wdata = l_rdata + 1'b1;
                end
            end
            ST_AP_TW: if (t_rdata == '0) begin
                t_we = 1'b1; t_wdata = cur_reg;
            end
            ST_AP_TDEC:  k_addr = p_reg;
            ST_AP_QLEN:  l_addr = t_rdata;
            ST_AP_QLENW: l_addr = p_reg;
            ST_AP_PLENW: k_addr = q_reg;
            ST_AP_CPY_RD: t_addr = cell_addr(q_reg, col_reg);
            ST_AP_CPY_WR: begin
                t_we = 1'b1; t_addr = cell_addr(cl_reg, col_reg); t_wdata = t_rdata;
                // q now links to the clone; its old link is already in cpy_reg
                if (col_reg == '0) begin
                    k_we = 1'b1; k_addr = q_reg; k_wdata = cl_reg;
                end
            end
            ST_AP_QLINKW: begin
                k_we = 1'b1; k_addr = cl_reg; k_wdata = cpy_reg;
                l_we = 1'b1; l_addr = cl_reg; l_wdata = plen_reg + 1'b1;
            end
            ST_AP_RW: if (t_rdata == q_reg) begin
                t_we = 1'b1; t_wdata = cl_reg;
            end
            ST_AP_RDEC:  k_addr = p_reg;
            ST_AP_FIN: begin
                k_we = 1'b1; k_addr = cur_reg;
                k_wdata = found_reg ? (res_reg.cloned ? cl_reg : q_reg) : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sweep_reg <= '0;
            mv_reg    <= 1'b0;
            used_reg  <= CW'(1);
            nsym_reg  <= '0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) mv_reg <= 1'b0;
            case (state_reg)
                ST_INIT: sweep_reg <= sweep_reg + 1'b1;
                ST_IDLE: if (s_valid && s_ready) begin
                    op_reg  <= s_data.operation;
                    sym_reg <= s_data.symbol;
                    idx_reg <= s_data.state_index;
                    res_reg <= '0;
                    found_reg <= 1'b0;
                    col_reg <= '0;
                end
                ST_DISPATCH: begin
                    if (op_reg == OP_APPEND && full_now) res_reg.full_res <= 1'b1;
                    if (op_reg == OP_APPEND && !full_now && sym_ok) begin
                        cur_reg  <= SW'(used_reg);
                        p_reg    <= last_reg;
                        used_reg <= used_reg + 1'b1;
                        nsym_reg <= nsym_reg + 1'b1;
                        last_reg <= SW'(used_reg);
                    end
                    if (op_reg == OP_CLEAR) begin
                        used_reg <= CW'(1); nsym_reg <= '0; last_reg <= '0;
                        sweep_reg <= '0;
                    end
                end
                ST_RD_WAIT: if (sym_ok && 32'(idx_reg) < 32'(used_reg)
                                && 32'(idx_reg) < MaxStates)
                    res_reg.read_target <= IndexWidth'(t_rdata);
                ST_AP_ROWCLR: col_reg <= last_col ? '0 : col_reg + 1'b1;
                ST_AP_TW: if (t_rdata != '0) begin
                    found_reg <= 1'b1; q_reg <= t_rdata;
                end
                ST_AP_LINKW: p_reg <= k_rdata;
                ST_AP_QLENW: plen_reg <= l_rdata;
                ST_AP_PLENW: begin
                    plen_reg <= l_rdata;
                    if (plen_reg != l_rdata + 1'b1) begin
                        cl_reg <= SW'(used_reg);
                        used_reg <= used_reg + 1'b1;
                        res_reg.cloned <= 1'b1;
                    end
                end
                ST_AP_CPY_RD: if (col_reg == '0) cpy_reg <= k_rdata;
                ST_AP_CPY_WR: col_reg <= last_col ? '0 : col_reg + 1'b1;
                ST_AP_RLINKW: p_reg <= k_rdata;
                ST_AP_FIN: res_reg.new_state_link <= IndexWidth'(k_wdata);
                ST_RESP: begin
                    mv_reg <= 1'b1;
                    res_reg.state_count <= CountWidth'(used_reg);
                end
                default: ;
            endcase
        end
    end

endmodule
